@@ design/dreq_pkg.sv @@
package dreq_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWAP_SCAN,
      ST_READ_SCAN,
      ST_READ_DIR,
      ST_READ_SWEEP,
      ST_SHIFT_INS,
      ST_SHIFT_REM,
      ST_REM_DIR,
      ST_RESULT
   } state_type;

   localparam logic [1:0] KIND_SWAP  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_BAD   = 2'd3;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

endpackage

@@ design/disk_request_elevator_queue_top.sv @@
// Elevator-ordered disk request queue: swaps first in arrival order, then reads in
// sweep order, then writes in arrival order. The queue lives in a memory with one read
// and one write port that one sequencer walks word by word: a read insert scans back from
// the tail and a swap insert forward from the head (up to QUEUE_DEPTH reads), and then the
// later words move up one place, each read and then written; a remove reads the head and
// moves every later word down one place, each read and then written. One word is handled
// at a time; req_ready is low until the result word is taken.
module disk_request_elevator_queue_top #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_cylinder,
   input  logic [7:0]  req_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_out_tag,
   output logic [1:0]  rsp_out_kind,
   output logic [15:0] rsp_out_cylinder,
   output logic        rsp_out_up,
   output logic [4:0]  rsp_out_position
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  tag;
      logic [1:0]  kind;
      logic [15:0] cyl;
      logic        up;
   } entry_type;

   entry_type mem [QUEUE_DEPTH];

   dreq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dev_up_ff, dev_up_in;
   logic [CW-1:0] t_ff, t_in;          // scan / shift index
   logic [CW-1:0] pos_ff, pos_in;      // insert position
   logic          up_ff, up_in;
   logic          bad_ff, bad_in;
   logic          phase_ff, phase_in;  // shift: 0 issue read, 1 write
   entry_type     new_ff;
   logic          act_ff;
   entry_type     rd_ff;
   entry_type     head_ff;
   logic [1:0]    st_ff, st_in;

   // memory port control
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[mem_raddr];
   end

   logic accept;
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == dreq_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == dreq_pkg::ST_RESULT);

   logic [1:0] kind_n;
   assign kind_n = (req_kind == 2'd3) ? dreq_pkg::KIND_WRITE : req_kind;

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      dev_up_in = dev_up_ff;
      t_in = t_ff;
      pos_in = pos_ff;
      up_in = up_ff;
      bad_in = bad_ff;
      phase_in = phase_ff;
      st_in = st_ff;
      mem_we = 1'b0;
      mem_waddr = t_ff[IW-1:0];
      mem_wdata = rd_ff;
      mem_raddr = t_ff[IW-1:0];
      case (state_ff)
         dreq_pkg::ST_IDLE: begin
            if (accept) begin
               bad_in = 1'b0;
               up_in = 1'b0;
               st_in = dreq_pkg::STATUS_OK;
               phase_in = 1'b0;
               if (req_action == dreq_pkg::ACT_REMOVE) begin
                  if (count_ff == '0) begin
                     st_in = dreq_pkg::STATUS_EMPTY;
                     state_in = dreq_pkg::ST_RESULT;
                  end else begin
                     t_in = '0;
                     mem_raddr = '0;
                     state_in = dreq_pkg::ST_SHIFT_REM;
                  end
               end else if (count_ff >= CW'(QUEUE_DEPTH)) begin
                  st_in = dreq_pkg::STATUS_FULL;
                  state_in = dreq_pkg::ST_RESULT;
               end else if (count_ff == '0) begin
                  dev_up_in = 1'b1;
                  up_in = 1'b1;
                  pos_in = '0;
                  t_in = '0;
                  state_in = dreq_pkg::ST_SHIFT_INS;
               end else if (kind_n == dreq_pkg::KIND_WRITE) begin
                  pos_in = count_ff;
                  t_in = count_ff;
                  state_in = dreq_pkg::ST_SHIFT_INS;
               end else if (kind_n == dreq_pkg::KIND_SWAP) begin
                  t_in = '0;
                  mem_raddr = '0;
                  state_in = dreq_pkg::ST_SWAP_SCAN;
               end else begin
                  t_in = count_ff - 1'b1;
                  mem_raddr = IW'(count_ff - 1'b1);
                  state_in = dreq_pkg::ST_READ_SCAN;
               end
            end
         end
         // first non-swap entry from the head
         dreq_pkg::ST_SWAP_SCAN: begin
            if (rd_ff.kind != dreq_pkg::KIND_SWAP) begin
               pos_in = (t_ff == '0) ? CW'(1) : t_ff;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else if (t_ff + 1'b1 == count_ff) begin
               pos_in = count_ff;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else begin
               t_in = t_ff + 1'b1;
               mem_raddr = IW'(t_ff + 1'b1);
            end
         end
         // back from tail to the last read, a swap, or the head
         dreq_pkg::ST_READ_SCAN: begin
            if (t_ff == '0) begin
               dev_up_in = 1'b1;
               up_in = 1'b1;
               pos_in = CW'(1);
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else if (rd_ff.kind == dreq_pkg::KIND_SWAP) begin
               dev_up_in = 1'b1;
               up_in = 1'b1;
               pos_in = t_ff + 1'b1;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else if (rd_ff.kind == dreq_pkg::KIND_READ) begin
               state_in = dreq_pkg::ST_READ_DIR;
            end else begin
               t_in = t_ff - 1'b1;
               mem_raddr = IW'(t_ff - 1'b1);
            end
         end
         // compare with the last read
         dreq_pkg::ST_READ_DIR: begin
            mem_raddr = t_ff[IW-1:0];
            if (dev_up_ff == rd_ff.up) begin
               if (!dev_up_ff && new_ff.cyl <= rd_ff.cyl) up_in = 1'b0;
               else if (dev_up_ff && new_ff.cyl >= rd_ff.cyl) up_in = 1'b1;
               else up_in = !dev_up_ff;
               pos_in = t_ff + 1'b1;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else begin
               up_in = rd_ff.up;
               state_in = dreq_pkg::ST_READ_SWEEP;
            end
         end
         // walk the second sweep back toward the head
         dreq_pkg::ST_READ_SWEEP: begin
            if (t_ff == '0) begin
               bad_in = 1'b1;
               st_in = dreq_pkg::STATUS_BAD;
               pos_in = count_ff;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else if (rd_ff.kind != dreq_pkg::KIND_READ || rd_ff.up != up_ff ||
                  (up_ff ? (rd_ff.cyl <= new_ff.cyl) : (rd_ff.cyl >= new_ff.cyl))) begin
               pos_in = t_ff + 1'b1;
               t_in = count_ff;
               state_in = dreq_pkg::ST_SHIFT_INS;
            end else begin
               t_in = t_ff - 1'b1;
               mem_raddr = IW'(t_ff - 1'b1);
            end
         end
         // move words up from the tail, then write the new word
         dreq_pkg::ST_SHIFT_INS: begin
            if (t_ff == pos_ff) begin
               mem_we = 1'b1;
               mem_waddr = pos_ff[IW-1:0];
               mem_wdata = '{tag: new_ff.tag, kind: new_ff.kind,
                             cyl: new_ff.cyl, up: up_ff};
               count_in = count_ff + 1'b1;
               state_in = dreq_pkg::ST_RESULT;
            end else if (!phase_ff) begin
               mem_raddr = IW'(t_ff - 1'b1);
               phase_in = 1'b1;
            end else begin
               mem_we = 1'b1;
               mem_waddr = t_ff[IW-1:0];
               t_in = t_ff - 1'b1;
               phase_in = 1'b0;
            end
         end
         // move words down toward the head
         dreq_pkg::ST_SHIFT_REM: begin
            if (!phase_ff) begin
               mem_raddr = IW'(t_ff + 1'b1);
               phase_in = 1'b1;
               if (t_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  t_in = CW'(1);
                  mem_raddr = IW'(1);
                  state_in = dreq_pkg::ST_REM_DIR;
               end
            end else begin
               mem_we = 1'b1;
               mem_waddr = t_ff[IW-1:0];
               t_in = t_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         // adopt the direction of the read after the new head
         dreq_pkg::ST_REM_DIR: begin
            if (count_ff >= CW'(2) && rd_ff.kind == dreq_pkg::KIND_READ)
               dev_up_in = rd_ff.up;
            state_in = dreq_pkg::ST_RESULT;
         end
         dreq_pkg::ST_RESULT: begin
            if (rsp_ready) state_in = dreq_pkg::ST_IDLE;
         end
         default: state_in = dreq_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dreq_pkg::ST_IDLE;
         count_ff <= '0;
         dev_up_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         dev_up_ff <= dev_up_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      t_ff <= t_in;
      pos_ff <= pos_in;
      up_ff <= up_in;
      bad_ff <= bad_in;
      phase_ff <= phase_in;
      st_ff <= st_in;
      if (accept) begin
         act_ff <= req_action;
         new_ff <= '{tag: req_tag, kind: kind_n, cyl: req_cylinder, up: 1'b0};
      end
      // head word is the first read of a remove
      if (state_ff == dreq_pkg::ST_SHIFT_REM && t_ff == '0 && !phase_ff)
         head_ff <= rd_ff;
   end

   // result word
   always_comb begin
      rsp_status = st_ff;
      rsp_out_tag = '0;
      rsp_out_kind = '0;
      rsp_out_cylinder = '0;
      rsp_out_up = 1'b0;
      rsp_out_position = '0;
      if (st_ff == dreq_pkg::STATUS_OK || st_ff == dreq_pkg::STATUS_BAD) begin
         if (act_ff == dreq_pkg::ACT_REMOVE) begin
            rsp_out_tag = head_ff.tag;
            rsp_out_kind = head_ff.kind;
            rsp_out_cylinder = head_ff.cyl;
            rsp_out_up = head_ff.up;
         end else begin
            rsp_out_up = up_ff;
            rsp_out_position = 5'(pos_ff);
         end
      end
   end

endmodule

@@ verif/disk_request_elevator_queue_top_tb.sv @@
`timescale 1ns / 100ps

module disk_request_elevator_queue_top_tb;

   localparam int DEPTH = 32;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1050;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  tag;
      logic [1:0]  kind;
      logic [15:0] cylinder;
      logic        up;
      logic [4:0]  position;
   } rsp_word_type;

   typedef struct {
      logic        action;
      logic [1:0]  kind;
      logic [15:0] cylinder;
      logic [7:0]  tag;
      bit          typed;
      rsp_word_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [1:0]  req_kind = 2'd0;
   logic [15:0] req_cylinder = 16'd0;
   logic [7:0]  req_tag = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_tag;
   logic [1:0]  rsp_out_kind;
   logic [15:0] rsp_out_cylinder;
   logic        rsp_out_up;
   logic [4:0]  rsp_out_position;

   // shadow copy of the queue
   logic [7:0]  q_tag [DEPTH];
   logic [1:0]  q_kind [DEPTH];
   logic [15:0] q_cyl [DEPTH];
   logic        q_up [DEPTH];
   int          q_count;
   logic        sweep_up;

   rsp_word_type pending_words[$];
   int          fail_count = 0;
   int          idle_send = 0;
   int          idle_recv = 0;
   int          stall_cycles = 0;
   int          n_insert = 0, n_remove = 0, n_full = 0, n_empty = 0, n_bad = 0;
   int          checked = 0;

   disk_request_elevator_queue_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_kind(req_kind),
      .req_cylinder(req_cylinder), .req_tag(req_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_out_tag(rsp_out_tag),
      .rsp_out_kind(rsp_out_kind), .rsp_out_cylinder(rsp_out_cylinder),
      .rsp_out_up(rsp_out_up), .rsp_out_position(rsp_out_position)
   );

   always #5 clock = ~clock;

   // open a slot at pos and shift later entries up
   function automatic void slot_in(int pos, logic [7:0] tg, logic [1:0] kd,
                                   logic [15:0] cy, logic u);
      for (int i = q_count; i > pos; i--) begin
         q_tag[i] = q_tag[i-1];
         q_kind[i] = q_kind[i-1];
         q_cyl[i] = q_cyl[i-1];
         q_up[i] = q_up[i-1];
      end
      q_tag[pos] = tg;
      q_kind[pos] = kd;
      q_cyl[pos] = cy;
      q_up[pos] = u;
      q_count++;
   endfunction

   // position after which a read goes, with its direction mark
   function automatic int read_after(logic [15:0] cy, output logic u, output bit bad);
      int t;
      t = q_count - 1;
      bad = 0;
      u = 1'b0;
      while (t != 0) begin
         if (q_kind[t] == dreq_pkg::KIND_SWAP) begin
            sweep_up = 1'b1;
            u = 1'b1;
            return t;
         end
         if (q_kind[t] == dreq_pkg::KIND_READ) break;
         t--;
      end
      if (t == 0) begin
         sweep_up = 1'b1;
         u = 1'b1;
         return 0;
      end
      if (sweep_up == q_up[t]) begin
         if (!sweep_up && cy <= q_cyl[t]) begin
            u = 1'b0;
            return t;
         end
         if (sweep_up && cy >= q_cyl[t]) begin
            u = 1'b1;
            return t;
         end
         u = ~sweep_up;
         return t;
      end
      if (q_up[t]) begin
         u = 1'b1;
         for (; t != 0; t--)
            if (q_kind[t] != dreq_pkg::KIND_READ || !q_up[t] || q_cyl[t] <= cy) return t;
      end else begin
         u = 1'b0;
         for (; t != 0; t--)
            if (q_kind[t] != dreq_pkg::KIND_READ || q_up[t] || q_cyl[t] >= cy) return t;
      end
      bad = 1;
      return q_count - 1;
   endfunction

   // expected word for one request, updating the shadow queue
   function automatic rsp_word_type queue_step(logic act, logic [1:0] kd, logic [15:0] cy,
                                               logic [7:0] tg);
      rsp_word_type w;
      int t;
      logic u;
      bit bad;
      w = '0;
      if (act == dreq_pkg::ACT_REMOVE) begin
         n_remove++;
         if (q_count == 0) begin
            w.status = dreq_pkg::STATUS_EMPTY;
            n_empty++;
            return w;
         end
         w.tag = q_tag[0];
         w.kind = q_kind[0];
         w.cylinder = q_cyl[0];
         w.up = q_up[0];
         for (int i = 1; i < q_count; i++) begin
            q_tag[i-1] = q_tag[i];
            q_kind[i-1] = q_kind[i];
            q_cyl[i-1] = q_cyl[i];
            q_up[i-1] = q_up[i];
         end
         q_count--;
         if (q_count >= 2 && q_kind[1] == dreq_pkg::KIND_READ) sweep_up = q_up[1];
         return w;
      end
      n_insert++;
      if (q_count >= DEPTH) begin
         w.status = dreq_pkg::STATUS_FULL;
         n_full++;
         return w;
      end
      if (kd == 2'd3) kd = dreq_pkg::KIND_WRITE;
      if (q_count == 0) begin
         sweep_up = 1'b1;
         slot_in(0, tg, kd, cy, 1'b1);
         w.up = 1'b1;
         return w;
      end
      t = 0;
      u = 1'b0;
      bad = 0;
      if (kd == dreq_pkg::KIND_SWAP) begin
         for (int i = 0; i < q_count; i++) begin
            if (q_kind[i] != dreq_pkg::KIND_SWAP) break;
            t = i;
         end
      end else if (kd == dreq_pkg::KIND_WRITE) begin
         t = q_count - 1;
      end else begin
         t = read_after(cy, u, bad);
      end
      slot_in(t + 1, tg, kd, cy, u);
      w.status = bad ? dreq_pkg::STATUS_BAD : dreq_pkg::STATUS_OK;
      if (bad) n_bad++;
      w.up = u;
      w.position = 5'(t + 1);
      return w;
   endfunction

   // hand one word to the block and record what it should answer
   task automatic send_word(logic act, logic [1:0] kd, logic [15:0] cy, logic [7:0] tg,
                            bit typed, rsp_word_type want);
      rsp_word_type w;
      while ($urandom_range(99) < idle_send) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_kind <= kd;
      req_cylinder <= cy;
      req_tag <= tg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      w = queue_step(act, kd, cy, tg);
      pending_words.push_back(typed ? want : w);
   endtask

   // result side: check each accepted word, then pick the next ready
   always @(posedge clock) begin
      rsp_word_type w;
      if (rsp_valid && rsp_ready) begin
         checked++;
         if (pending_words.size() == 0) begin
            $error("unexpected result word");
            fail_count++;
         end else begin
            w = pending_words.pop_front();
            if (rsp_status !== w.status) begin
               $error("status expected %0d actual %0d", w.status, rsp_status);
               fail_count++;
            end
            if (rsp_out_tag !== w.tag) begin
               $error("out_tag expected %0d actual %0d", w.tag, rsp_out_tag);
               fail_count++;
            end
            if (rsp_out_kind !== w.kind) begin
               $error("out_kind expected %0d actual %0d", w.kind, rsp_out_kind);
               fail_count++;
            end
            if (rsp_out_cylinder !== w.cylinder) begin
               $error("out_cylinder expected %0d actual %0d", w.cylinder, rsp_out_cylinder);
               fail_count++;
            end
            if (rsp_out_up !== w.up) begin
               $error("out_up expected %0d actual %0d", w.up, rsp_out_up);
               fail_count++;
            end
            if (rsp_out_position !== w.position) begin
               $error("out_position expected %0d actual %0d", w.position, rsp_out_position);
               fail_count++;
            end
         end
      end
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= idle_recv);
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("disk_request_elevator_queue_top regression: fail");
            $finish;
         end
      end
   end

   // random cylinder, biased towards extremes and a narrow band for ties
   function automatic logic [15:0] pick_cylinder();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3, 4: return 16'(1000 + $urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      dir_row_type rows[$];
      dir_row_type r;
      rsp_word_type z;
      int fill_bias;
      z = '0;
      q_count = 0;
      sweep_up = 1'b0;

      // directed rows: empty remove and first insert are typed in
      r = '{dreq_pkg::ACT_REMOVE, dreq_pkg::KIND_SWAP, 16'd0, 8'd0, 1, z};
      r.want.status = dreq_pkg::STATUS_EMPTY;
      rows.push_back(r);
      r = '{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'd100, 8'h01, 1, z};
      r.want.up = 1'b1;
      rows.push_back(r);
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_SWAP, 16'd500, 8'h02, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'h0000, 8'h03, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'hFFFF, 8'hFF, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_WRITE, 16'd7, 8'h04, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, 2'd3, 16'hAAAA, 8'h55, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_SWAP, 16'h5555, 8'hAA, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'd300, 8'h00, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'd50, 8'h10, 0, z});
      rows.push_back('{dreq_pkg::ACT_INSERT, dreq_pkg::KIND_READ, 16'd50, 8'h11, 0, z});
      for (int i = 0; i < 10; i++)
         rows.push_back('{dreq_pkg::ACT_REMOVE, 2'(i), 16'hFFFF, 8'hFF, 0, z});
      r = '{dreq_pkg::ACT_REMOVE, dreq_pkg::KIND_READ, 16'hFFFF, 8'hFF, 1, z};
      r.want.status = dreq_pkg::STATUS_EMPTY;
      rows.push_back(r);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_send = 34;
      idle_recv = 48;
      foreach (rows[i])
         send_word(rows[i].action, rows[i].kind, rows[i].cylinder, rows[i].tag,
                   rows[i].typed, rows[i].want);

      // random traffic in bursts that fill and then drain the queue
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            idle_send = 48;
            idle_recv = 34;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            idle_send = 0;
            idle_recv = 0;
         end
         fill_bias = ((n / 50) % 2 == 0) ? 85 : 25;
         send_word(($urandom_range(99) < fill_bias) ? dreq_pkg::ACT_INSERT
                                                     : dreq_pkg::ACT_REMOVE,
                   2'($urandom), pick_cylinder(), 8'($urandom), 0, z);
      end
      req_valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         $error("%0d result words never arrived", pending_words.size());
         fail_count++;
      end

      $display("covered %0d inserts and %0d removes, %0d words checked",
               n_insert, n_remove, checked);
      $display("queue full %0d, queue empty %0d, read order fallback %0d",
               n_full, n_empty, n_bad);
      if (fail_count == 0) begin
         $display("disk_request_elevator_queue_top regression: pass");
      end else begin
         $display("disk_request_elevator_queue_top regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dreq_pkg.sv
design/disk_request_elevator_queue_top.sv
verif/disk_request_elevator_queue_top_tb.sv
